>>> rtl/fau_pkg.sv
// fau_pkg: shared types, widths, codes and rounding helpers of the
// filtered ampere update block; no dependencies
`default_nettype none

package fau_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 60;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam int THETA_W = 17;
  localparam int ALPHA_W = 18;
  localparam int BETA_W  = 17;
  localparam int DELTA_W = 17;
  localparam int DT_W    = 24;
  localparam int DSTEP_W = 17;

  // component selector codes
  localparam logic [1:0] FUNC_EX = 2'd0;
  localparam logic [1:0] FUNC_EY = 2'd1;
  localparam logic [1:0] FUNC_EZ = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THETA = 4'd0,
    REG_ALPHA = 4'd1,
    REG_BETA  = 4'd2,
    REG_DELTA = 4'd3,
    REG_DT    = 4'd4,
    REG_DTDX  = 4'd5,
    REG_DTDY  = 4'd6,
    REG_DTDZ  = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] current_density;
    logic signed [DATA_W-1:0] first_curl_diff;
    logic signed [DATA_W-1:0] second_curl_diff;
    logic signed [DATA_W-1:0] field_old;
    logic signed [DATA_W-1:0] history_one;
    logic signed [DATA_W-1:0] history_two;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] field_new;
    logic signed [DATA_W-1:0] field_filtered;
    logic signed [DATA_W-1:0] history_one_new;
    logic signed [DATA_W-1:0] history_two_new;
  } out_t;

  typedef struct packed {
    logic [THETA_W-1:0] theta;
    logic [ALPHA_W-1:0] coef_alpha;
    logic [BETA_W-1:0]  coef_beta;
    logic [DELTA_W-1:0] coef_delta;
    logic [DT_W-1:0]    time_step;
    logic [DSTEP_W-1:0] step_over_dx;
    logic [DSTEP_W-1:0] step_over_dy;
    logic [DSTEP_W-1:0] step_over_dz;
  } cfg_t;

  // increment stage result handed to the field stage
  typedef struct packed {
    logic signed [DATA_W-1:0] field_old;
    logic signed [DATA_W-1:0] adv;
    logic signed [DATA_W-1:0] h2_new;
    logic signed [ACC_W-1:0]  part;
  } incr_t;

  // field stage result handed to the filter stages
  typedef struct packed {
    logic signed [DATA_W-1:0] field_new;
    logic signed [DATA_W-1:0] adv;
    logic signed [DATA_W-1:0] h1_new;
    logic signed [DATA_W-1:0] h2_new;
    logic signed [ACC_W-1:0]  part;
  } field_t;

  // Q.32 to Q16.16, round half up, saturate to 32 bits
  function automatic logic signed [DATA_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] x
  );
    localparam logic signed [ACC_W-1:0] RndHalf = ACC_W'(1 << (FRAC_W - 1));
    localparam logic signed [ACC_W-FRAC_W-1:0] QMax = (ACC_W - FRAC_W)'(2147483647);
    localparam logic signed [ACC_W-FRAC_W-1:0] QMin = -QMax - 1;
    logic signed [ACC_W-1:0]        y;
    logic signed [ACC_W-FRAC_W-1:0] q;
    y = x + RndHalf;
    q = y[ACC_W-1:FRAC_W];
    if (q > QMax) begin
      round_sat = QMax[DATA_W-1:0];
    end else if (q < QMin) begin
      round_sat = QMin[DATA_W-1:0];
    end else begin
      round_sat = q[DATA_W-1:0];
    end
  endfunction

  // saturate a 33-bit sum to 32 bits
  function automatic logic signed [DATA_W-1:0] sat_word(
    input logic signed [DATA_W:0] x
  );
    if (x[DATA_W] != x[DATA_W-1]) begin
      sat_word = x[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_word = x[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/fau_cfg.sv
// fau_cfg: configuration register file with reset values
// depends on fau_pkg
`default_nettype none

module fau_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fau_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fau_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output fau_pkg::cfg_t                       cfg_o
);

  fau_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (fau_pkg::cfg_idx_e'(cfg_index_i))
        fau_pkg::REG_THETA: cfg_d.theta        = cfg_data_i[fau_pkg::THETA_W-1:0];
        fau_pkg::REG_ALPHA: cfg_d.coef_alpha   = cfg_data_i[fau_pkg::ALPHA_W-1:0];
        fau_pkg::REG_BETA:  cfg_d.coef_beta    = cfg_data_i[fau_pkg::BETA_W-1:0];
        fau_pkg::REG_DELTA: cfg_d.coef_delta   = cfg_data_i[fau_pkg::DELTA_W-1:0];
        fau_pkg::REG_DT:    cfg_d.time_step    = cfg_data_i[fau_pkg::DT_W-1:0];
        fau_pkg::REG_DTDX:  cfg_d.step_over_dx = cfg_data_i[fau_pkg::DSTEP_W-1:0];
        fau_pkg::REG_DTDY:  cfg_d.step_over_dy = cfg_data_i[fau_pkg::DSTEP_W-1:0];
        fau_pkg::REG_DTDZ:  cfg_d.step_over_dz = cfg_data_i[fau_pkg::DSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.theta        <= '0;
      cfg_q.coef_alpha   <= fau_pkg::ALPHA_W'(65536);
      cfg_q.coef_beta    <= '0;
      cfg_q.coef_delta   <= '0;
      cfg_q.time_step    <= fau_pkg::DT_W'(65536);
      cfg_q.step_over_dx <= '0;
      cfg_q.step_over_dy <= '0;
      cfg_q.step_over_dz <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fau_incr.sv
// fau_incr: stages 1 and 2, source, curl and history products, increment and second history
// depends on fau_pkg
`default_nettype none

module fau_incr (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  fau_pkg::in_t       data_i,
  input  fau_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output fau_pkg::incr_t     data_o
);

  localparam int PJ_W = fau_pkg::DT_W + 1 + fau_pkg::DATA_W;
  localparam int PC_W = fau_pkg::DSTEP_W + 1 + fau_pkg::DATA_W;
  localparam int PH_W = fau_pkg::THETA_W + 1 + fau_pkg::DATA_W;

  // stage 1 registers
  logic                             s1_valid_q;
  logic signed [PJ_W-1:0]           s1_pj_q;
  logic signed [PC_W-1:0]           s1_p1_q, s1_p2_q;
  logic                             s1_neg1_q, s1_neg2_q;
  logic signed [PH_W-1:0]           s1_pdh1_q, s1_pth2_q;
  logic signed [fau_pkg::DATA_W-1:0] s1_eold_q, s1_h1_q;

  logic [fau_pkg::DSTEP_W-1:0] c1, c2;
  logic                        neg1, neg2;

  // coefficient and sign pick per component
  always_comb begin
    c1   = '0;
    c2   = '0;
    neg1 = 1'b0;
    neg2 = 1'b0;
    unique case (data_i.func)
      fau_pkg::FUNC_EX: begin
        c1 = cfg_i.step_over_dy;
        c2 = cfg_i.step_over_dz;
        neg2 = 1'b1;
      end
      fau_pkg::FUNC_EY: begin
        c1 = cfg_i.step_over_dx;
        c2 = cfg_i.step_over_dz;
        neg1 = 1'b1;
      end
      fau_pkg::FUNC_EZ: begin
        c1 = cfg_i.step_over_dx;
        c2 = cfg_i.step_over_dy;
        neg2 = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pj_q   <= PJ_W'($signed({1'b0, cfg_i.time_step}))
                 * PJ_W'($signed(data_i.current_density));
    s1_p1_q   <= PC_W'($signed({1'b0, c1})) * PC_W'($signed(data_i.first_curl_diff));
    s1_p2_q   <= PC_W'($signed({1'b0, c2})) * PC_W'($signed(data_i.second_curl_diff));
    s1_neg1_q <= neg1;
    s1_neg2_q <= neg2;
    s1_pdh1_q <= PH_W'($signed({1'b0, cfg_i.coef_delta}))
                 * PH_W'($signed(data_i.history_one));
    s1_pth2_q <= PH_W'($signed({1'b0, cfg_i.theta})) * PH_W'($signed(data_i.history_two));
    s1_eold_q <= data_i.field_old;
    s1_h1_q   <= data_i.history_one;
  end

  // stage 2: sums in Q.32; the increment and second history get one rounding each
  logic signed [fau_pkg::ACC_W-1:0] t1, t2, acc_adv, acc_h2;
  fau_pkg::incr_t                   s2_d, s2_q;
  logic                             s2_valid_q;

  always_comb begin
    t1 = fau_pkg::ACC_W'(s1_p1_q);
    t2 = fau_pkg::ACC_W'(s1_p2_q);
    if (s1_neg1_q) begin
      t1 = -t1;
    end
    if (s1_neg2_q) begin
      t2 = -t2;
    end
    acc_adv = t1 + t2 - fau_pkg::ACC_W'(s1_pj_q);
    acc_h2  = (fau_pkg::ACC_W'(s1_h1_q) <<< fau_pkg::FRAC_W) - fau_pkg::ACC_W'(s1_pth2_q);
    s2_d.field_old = s1_eold_q;
    s2_d.adv       = fau_pkg::round_sat(acc_adv);
    s2_d.h2_new    = fau_pkg::round_sat(acc_h2);
    s2_d.part      = fau_pkg::ACC_W'(s1_pdh1_q) + fau_pkg::ACC_W'(s1_pth2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_q;

endmodule

`default_nettype wire

>>> rtl/fau_field.sv
// fau_field: stage 3, new field and first history with saturation
// depends on fau_pkg
`default_nettype none

module fau_field (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  fau_pkg::incr_t  data_i,
  output logic            valid_o,
  output fau_pkg::field_t data_o
);

  fau_pkg::field_t s3_d, s3_q;
  logic            s3_valid_q;
  logic signed [fau_pkg::DATA_W-1:0] enew;

  always_comb begin
    enew = fau_pkg::sat_word((fau_pkg::DATA_W + 1)'(data_i.field_old)
                             + (fau_pkg::DATA_W + 1)'(data_i.adv));
    s3_d.field_new = enew;
    s3_d.adv       = data_i.adv;
    s3_d.h1_new    = fau_pkg::sat_word((fau_pkg::DATA_W + 1)'(enew)
                                       - (fau_pkg::DATA_W + 1)'(data_i.adv));
    s3_d.h2_new    = data_i.h2_new;
    s3_d.part      = data_i.part;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  assign valid_o = s3_valid_q;
  assign data_o  = s3_q;

endmodule

`default_nettype wire

>>> rtl/fau_filt.sv
// fau_filt: stages 4 and 5, weight products and filtered field, result register
// depends on fau_pkg
`default_nettype none

module fau_filt (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  fau_pkg::field_t data_i,
  input  fau_pkg::cfg_t   cfg_i,
  output logic            valid_o,
  output fau_pkg::out_t   data_o
);

  localparam int PA_W = fau_pkg::ALPHA_W + 1 + fau_pkg::DATA_W;
  localparam int PB_W = fau_pkg::BETA_W + 1 + fau_pkg::DATA_W;

  logic                              s4_valid_q;
  logic signed [PA_W-1:0]            s4_pa_q;
  logic signed [PB_W-1:0]            s4_pb_q;
  logic signed [fau_pkg::ACC_W-1:0]  s4_part_q;
  logic signed [fau_pkg::DATA_W-1:0] s4_enew_q, s4_h1n_q, s4_h2n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_pa_q   <= PA_W'($signed({1'b0, cfg_i.coef_alpha})) * PA_W'($signed(data_i.field_new));
    s4_pb_q   <= PB_W'($signed({1'b0, cfg_i.coef_beta})) * PB_W'($signed(data_i.adv));
    s4_part_q <= data_i.part;
    s4_enew_q <= data_i.field_new;
    s4_h1n_q  <= data_i.h1_new;
    s4_h2n_q  <= data_i.h2_new;
  end

  logic signed [fau_pkg::ACC_W-1:0] acc_filt;
  fau_pkg::out_t                    s5_d, s5_q;
  logic                             s5_valid_q;

  always_comb begin
    acc_filt = fau_pkg::ACC_W'(s4_pa_q) + fau_pkg::ACC_W'(s4_pb_q) + s4_part_q;
    s5_d.field_new       = s4_enew_q;
    s5_d.field_filtered  = fau_pkg::round_sat(acc_filt);
    s5_d.history_one_new = s4_h1n_q;
    s5_d.history_two_new = s4_h2n_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_q <= s5_d;
  end

  assign valid_o = s5_valid_q;
  assign data_o  = s5_q;

endmodule

`default_nettype wire

>>> rtl/friedman_filtered_ampere_update.sv
// friedman_filtered_ampere_update: top level of the per-cell field update with
// time filtering; depends on fau_pkg, fau_cfg, fau_incr, fau_field, fau_filt
//
//   channel   direction  handshake                  payload
//   command   in         start & !busy              in_data_i  (fau_pkg::in_t)
//   result    out        out_valid_o, one cycle     out_data_o (fau_pkg::out_t)
//   config    in         cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// one cell per clock; each transaction passes through the five register
// stages of the pipeline (products, increment, new field, filter
// products, filtered sum)
// busy stays low and cfg_ready_o stays high: the pipeline never stalls since
// the receiver takes every result as it comes
// reset clears the stage valid bits and loads the register reset values;
// data registers are not reset
`default_nettype none

module friedman_filtered_ampere_update (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // command channel
  input  wire logic                           start,
  output logic                                busy,
  input  fau_pkg::in_t                        in_data_i,
  // result channel
  output logic                                out_valid_o,
  output fau_pkg::out_t                       out_data_o,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fau_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fau_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fau_pkg::cfg_t   cfg;
  fau_pkg::incr_t  incr_data;
  fau_pkg::field_t field_data;
  logic            incr_valid, field_valid;

  // a new transaction enters every cycle
  assign busy = 1'b0;

  // registers are to be written only while the pipeline is empty, so stages
  // read them live; the user must keep to this, the block does not enforce it
  fau_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // stages 1-2: dt*J and curl products, rounded increment, second history
  fau_incr u_incr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .data_i  (in_data_i),
    .cfg_i   (cfg),
    .valid_o (incr_valid),
    .data_o  (incr_data)
  );

  // stage 3: saturated new field and first history
  fau_field u_field (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (incr_valid),
    .data_i  (incr_data),
    .valid_o (field_valid),
    .data_o  (field_data)
  );

  // stages 4-5: alpha/beta products, filtered sum, result register
  fau_filt u_filt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (field_valid),
    .data_i  (field_data),
    .cfg_i   (cfg),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire
